// ===== hw/rtl/bc_pkg.sv =====
// ----------------------------------------------------------------------------
// bc_pkg: shared types and constants of the bipartite check
// Request payloads of the three channels, configuration register indexes and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bc_pkg;

  // Fixed field widths
  localparam int VTX_W     = 6;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_VERTEX = 2'd1;

  // Reset values of the configuration registers
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 7'd64;
  localparam logic [VTX_W-1:0] START_VERTEX_RST = 6'd0;

  typedef struct packed {
    logic [VTX_W-1:0] edge_a;
    logic [VTX_W-1:0] edge_b;
    logic             has_edge;
    logic             last_edge;
  } edge_req_t;

  typedef struct packed {
    logic is_bipartite;
    logic bad_edge;
  } result_req_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;
  } cfg_req_t;

  // Controller to datapath
  typedef struct packed {
    logic load;      // accepted edge request: write matrix / flag error
    logic start;     // color start vertex, init walk
    logic row_rd;    // read adjacency row of top vertex
    logic scan_adv;  // no neighbor at scan position, step on
    logic hit;       // neighbor found at scan position
    logic pop;       // drop top entry, read the one below
    logic pop_load;  // take popped entry into the top registers
    logic clear;     // result taken: clear graph state
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start_oob;  // start vertex not below vertex count
    logic scan_end;   // scan position reached vertex count
    logic scan_hit;   // adjacency bit set at scan position
    logic u_colored;  // neighbor at scan position already colored
    logic conflict;   // neighbor color equals top color
    logic depth_one;  // only the start vertex on the stack
  } status_t;

endpackage

// ===== hw/rtl/bc_edge_if.sv =====
// ----------------------------------------------------------------------------
// bc_edge_if: edge request channel
// Valid/ready channel carrying one edge request per handshake.
// ----------------------------------------------------------------------------
interface bc_edge_if;
  import bc_pkg::*;

  logic      valid;
  logic      ready;
  edge_req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// ===== hw/rtl/bc_result_if.sv =====
// ----------------------------------------------------------------------------
// bc_result_if: result channel
// Valid/ready channel carrying one check result per handshake.
// ----------------------------------------------------------------------------
interface bc_result_if;
  import bc_pkg::*;

  logic        valid;
  logic        ready;
  result_req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// ===== hw/rtl/bc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface bc_cfg_if;
  import bc_pkg::*;

  logic     valid;
  logic     ready;
  cfg_req_t req;

  modport source (output valid, output req, input ready);
  modport sink (input valid, input req, output ready);
endinterface

// ===== hw/rtl/bc_datapath.sv =====
// ----------------------------------------------------------------------------
// bc_datapath: adjacency, color and stack storage of the bipartite check
// Holds the configuration registers, two adjacency copies (row a bit b and
// row b bit a), color flags and memory, the walk stack and its top entry.
// ----------------------------------------------------------------------------
module bc_datapath #(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  bc_pkg::cfg_req_t   cfg_req,
  input  bc_pkg::edge_req_t  edge_req,
  input  bc_pkg::cmd_t       cmd,
  output bc_pkg::status_t    status,
  output logic               edge_error
);
  import bc_pkg::*;

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;
  localparam int SW = VW + CW;

  // Configuration
  logic [CNT_W-1:0] vertex_count;
  logic [VTX_W-1:0] start_vertex;

  // Control state
  logic [MAX_VERTICES-1:0] vld_x;
  logic [MAX_VERTICES-1:0] vld_y;
  logic [MAX_VERTICES-1:0] colored;
  logic [CW-1:0]           depth;

  // Top of stack and scan position
  logic [VW-1:0] cur_v;
  logic [CW-1:0] scan;

  // Memories and their read registers
  logic [MAX_VERTICES-1:0] adj_x [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] adj_y [MAX_VERTICES];
  logic                    color_mem [MAX_VERTICES];
  logic [SW-1:0]           stack_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_x;
  logic [MAX_VERTICES-1:0] rd_y;
  logic                    rdv_x;
  logic                    rdv_y;
  logic                    color_rd;
  logic [SW-1:0]           stack_rd;

  // Derived values
  logic [NW-1:0]           n_eff;
  logic [NW-1:0]           a_n;
  logic [NW-1:0]           b_n;
  logic [NW-1:0]           s_n;
  logic [VW-1:0]           a_idx;
  logic [VW-1:0]           b_idx;
  logic [VW-1:0]           s_idx;
  logic [VW-1:0]           u_idx;
  logic                    edge_ok;
  logic                    start_ok;
  logic                    push_ok;
  logic [CW-1:0]           scan_inc;
  logic [CW-1:0]           dm1;
  logic [CW-1:0]           dm2;
  logic [MAX_VERTICES-1:0] row;

  // Effective vertex count, clamped to storage depth
  always_comb begin
    if (NW'(vertex_count) > NW'(MAX_VERTICES)) begin
      n_eff = NW'(MAX_VERTICES);
    end else begin
      n_eff = NW'(vertex_count);
    end
  end

  assign a_n      = NW'(edge_req.edge_a);
  assign b_n      = NW'(edge_req.edge_b);
  assign s_n      = NW'(start_vertex);
  assign a_idx    = a_n[VW-1:0];
  assign b_idx    = b_n[VW-1:0];
  assign s_idx    = s_n[VW-1:0];
  assign u_idx    = scan[VW-1:0];
  assign edge_ok  = (a_n < n_eff) && (b_n < n_eff);
  assign start_ok = s_n < n_eff;
  assign push_ok  = depth < CW'(MAX_VERTICES);
  assign scan_inc = scan + CW'(1);
  assign dm1      = depth - CW'(1);
  assign dm2      = depth - CW'(2);

  // Row of the top vertex; rows never written read as zero
  assign row = ({MAX_VERTICES{rdv_x}} & rd_x) | ({MAX_VERTICES{rdv_y}} & rd_y);

  // Status to controller
  always_comb begin
    status.start_oob = !start_ok;
    status.scan_end  = NW'(scan) >= n_eff;
    status.scan_hit  = !status.scan_end && row[u_idx];
    status.u_colored = colored[u_idx];
    status.conflict  = color_rd == ~depth[0];
    status.depth_one = depth == CW'(1);
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= VERTEX_COUNT_RST;
      start_vertex <= START_VERTEX_RST;
    end else if (cfg_we) begin
      unique case (cfg_req.index)
        CFG_VERTEX_COUNT: vertex_count <= cfg_req.data[CNT_W-1:0];
        CFG_START_VERTEX: start_vertex <= cfg_req.data[VTX_W-1:0];
        default: ;
      endcase
    end
  end

  // Row valid bits, color flags, error flag, stack depth
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      vld_x      <= '0;
      vld_y      <= '0;
      colored    <= '0;
      edge_error <= 1'b0;
      depth      <= '0;
    end else begin
      if (cmd.load && edge_req.has_edge) begin
        if (edge_ok) begin
          vld_x[a_idx] <= 1'b1;
          vld_y[b_idx] <= 1'b1;
        end else begin
          edge_error <= 1'b1;
        end
      end
      if (cmd.start && start_ok) begin
        colored[s_idx] <= 1'b1;
        depth          <= CW'(1);
      end
      if (cmd.hit && !colored[u_idx]) begin
        colored[u_idx] <= 1'b1;
        if (push_ok) begin
          depth <= depth + CW'(1);
        end
      end
      if (cmd.pop) begin
        depth <= dm1;
      end
    end
  end

  // Top entry and scan position
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      cur_v <= s_idx;
      scan  <= '0;
    end else if (cmd.scan_adv) begin
      scan <= scan_inc;
    end else if (cmd.hit) begin
      if (!colored[u_idx] && push_ok) begin
        cur_v <= u_idx;
        scan  <= '0;
      end else begin
        scan <= scan_inc;
      end
    end else if (cmd.pop_load) begin
      cur_v <= stack_rd[SW-1:CW];
      scan  <= stack_rd[CW-1:0];
    end
  end

  // Adjacency copies: bit-masked write, first write to a row clears the rest
  always_ff @(posedge clk) begin
    if (cmd.load && edge_req.has_edge && edge_ok) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (!vld_x[a_idx] || VW'(i) == b_idx) begin
          adj_x[a_idx][i] <= VW'(i) == b_idx;
        end
        if (!vld_y[b_idx] || VW'(i) == a_idx) begin
          adj_y[b_idx][i] <= VW'(i) == a_idx;
        end
      end
    end
  end

  // Adjacency read port
  always_ff @(posedge clk) begin
    if (cmd.row_rd) begin
      rd_x  <= adj_x[cur_v];
      rd_y  <= adj_y[cur_v];
      rdv_x <= vld_x[cur_v];
      rdv_y <= vld_y[cur_v];
    end
  end

  // Color memory: 0 for first color, 1 for second
  always_ff @(posedge clk) begin
    if (cmd.start && start_ok) begin
      color_mem[s_idx] <= 1'b0;
    end else if (cmd.hit && !colored[u_idx]) begin
      color_mem[u_idx] <= depth[0];
    end
    if (cmd.hit) begin
      color_rd <= color_mem[u_idx];
    end
  end

  // Walk stack below the top entry
  always_ff @(posedge clk) begin
    if (cmd.hit && !colored[u_idx] && push_ok) begin
      stack_mem[dm1[VW-1:0]] <= {cur_v, scan_inc};
    end
    if (cmd.pop) begin
      stack_rd <= stack_mem[dm2[VW-1:0]];
    end
  end

endmodule

// ===== hw/rtl/bc_ctrl.sv =====
// ----------------------------------------------------------------------------
// bc_ctrl: sequencer of the bipartite check
// Accepts edge requests, steps the depth-first coloring walk one scan position
// per cycle between row reads, checks and pops; presents the result until taken.
// ----------------------------------------------------------------------------
module bc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             is_bipartite,
  input  bc_pkg::status_t  status,
  output bc_pkg::cmd_t     cmd
);
  import bc_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_ROW,
    S_SCAN,
    S_CHECK,
    S_POP,
    S_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic   finish;
  logic   finish_val;

  assign in_ready = state == S_LOAD;

  // Commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    finish     = 1'b0;
    finish_val = 1'b1;
    unique case (state)
      S_LOAD: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_last) begin
            state_next = S_START;
          end
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        if (status.start_oob) begin
          finish = 1'b1;
        end else begin
          state_next = S_ROW;
        end
      end
      S_ROW: begin
        cmd.row_rd = 1'b1;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        if (status.scan_end) begin
          cmd.pop = 1'b1;
          if (status.depth_one) begin
            finish = 1'b1;
          end else begin
            state_next = S_POP;
          end
        end else if (status.scan_hit) begin
          cmd.hit    = 1'b1;
          state_next = status.u_colored ? S_CHECK : S_ROW;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      S_CHECK: begin
        if (status.conflict) begin
          finish     = 1'b1;
          finish_val = 1'b0;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_ROW;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.clear  = 1'b1;
          state_next = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
    if (finish) begin
      state_next = S_OUT;
    end
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= state_next == S_OUT;
      if (finish) begin
        is_bipartite <= finish_val;
      end
    end
  end

endmodule

// ===== hw/rtl/bipartite_check_core.sv =====
// ----------------------------------------------------------------------------
// bipartite_check_core: two-coloring check of an undirected graph
// Loads edges into an adjacency bit matrix and, on the last request, runs a
// depth-first walk from the start vertex to decide bipartiteness.
// ----------------------------------------------------------------------------
// Usage:
//   cfg    : register writes (index 0 vertex count, 1 start vertex); always
//            ready, write only while no graph is being checked.
//   edges  : one edge request per cycle while loading; has_edge low makes a
//            marker, last_edge high closes the graph and starts the check.
//            Edges naming a vertex at or above the vertex count are dropped
//            and flagged in bad_edge.
//   result : one request per graph; held until taken, then the matrix, color
//            and error state clear in the same cycle and edges is ready again.
// Walk: steps one scan position per cycle over each visited row, pausing for
//   row reads, color checks and pops; there is no walk if the start vertex is
//   out of range. A conflicting color stops the walk early.
//   edges is not ready from the last request until the result is taken.
// Reset: synchronous; clears graph state through row valid bits at once, so
//   no clearing pass is needed, and sets vertex count 64, start vertex 0.
// ----------------------------------------------------------------------------
module bipartite_check_core #(
  parameter int MAX_VERTICES = 64
) (
  input logic          clk,
  input logic          rst,
  bc_cfg_if.sink       cfg,
  bc_edge_if.sink      edges,
  bc_result_if.source  result
);
  import bc_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    edge_error;
  logic    is_bipartite;
  logic    cfg_we;

  // Config is accepted every cycle
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  bc_datapath #(
    .MAX_VERTICES (MAX_VERTICES)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_req    (cfg.req),
    .edge_req   (edges.req),
    .cmd        (cmd),
    .status     (status),
    .edge_error (edge_error)
  );

  bc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (edges.valid),
    .in_last      (edges.req.last_edge),
    .in_ready     (edges.ready),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .is_bipartite (is_bipartite),
    .status       (status),
    .cmd          (cmd)
  );

  // Result request
  assign result.req.is_bipartite = is_bipartite;
  assign result.req.bad_edge     = edge_error;

`ifndef ASSERT_OFF
  // Never loading while a result is pending
  a_no_load_with_result: assert property (@(posedge clk) disable iff (rst)
    !(edges.ready && result.valid))
    else $error("edge channel ready while result pending");

  // Last request stops loading
  a_last_stops_load: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.ready && edges.req.last_edge |=> !edges.ready)
    else $error("loading continued after last request");

  // Taking the result reopens the edge channel
  a_result_reopens: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ready |=> edges.ready && !result.valid)
    else $error("edge channel not reopened after result");
`endif

endmodule
